// ===== rtl/spiimu_pkg.sv =====
// Shared types, constants and the power-on map for the SPI IMU register slave.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package spiimu_pkg;

	localparam int ADDR_W      = 7;
	localparam int DEPTH       = 128;
	localparam int NUM_SENSORS = 7;
	localparam int CFG_IDX_W   = 3;

	localparam logic [6:0] INT_STATUS_ADDR = 7'h3A;
	localparam logic [6:0] SENSOR_BASE     = 7'h3B;
	localparam logic [6:0] SENSOR_LAST     = 7'h48;
	localparam logic [6:0] PWR_ADDR        = 7'h6B;
	localparam logic [6:0] WHOAMI_ADDR     = 7'h75;
	localparam logic [6:0] PRODID_ADDR     = 7'h0C;
	localparam logic [6:0] ADDR_MASK       = 7'h7F;

	localparam logic [7:0] WHOAMI_VAL   = 8'h68;
	localparam logic [7:0] PRODID_VAL   = 8'h54;
	localparam logic [7:0] PWR_DEFAULT  = 8'h40;
	localparam logic [7:0] DATA_RDY     = 8'h01;
	localparam int         READ_FLAG_BIT = 7;
	localparam int         PWR_RESET_BIT = 7;

	localparam logic signed [15:0] ACCEL_Z_RESET = 16'sd2048;

	typedef enum logic [1:0] {
		ACT_SEL_FALL = 2'd0,
		ACT_SPI_BYTE = 2'd1,
		ACT_SEL_RISE = 2'd2,
		ACT_HOST_WR  = 2'd3
	} action_t;

	typedef logic [NUM_SENSORS-1:0][15:0] sensor_bank_t;

	localparam sensor_bank_t SENSOR_RESET = {16'h0000, 16'h0000, 16'h0000, 16'h0000,
		ACCEL_Z_RESET, 16'h0000, 16'h0000};

	typedef struct packed {
		logic       wr_en;
		logic [6:0] wr_addr;
		logic [7:0] wr_data;
		logic       rd_en;
		logic [6:0] rd_addr;
		logic       soft_reset;
		logic       set_drdy;
	} reg_op_t;

	function automatic logic [7:0] default_byte(input logic [6:0] addr, input sensor_bank_t s);
		logic [6:0] off;
		logic [2:0] idx;
		logic [7:0] b;
		off = addr - SENSOR_BASE;
		idx = off[3:1];
		b   = 8'h00;
		if (addr == WHOAMI_ADDR) begin
			b = WHOAMI_VAL;
		end else if (addr == PRODID_ADDR) begin
			b = PRODID_VAL;
		end else if (addr == PWR_ADDR) begin
			b = PWR_DEFAULT;
		end else if (addr >= SENSOR_BASE && addr <= SENSOR_LAST) begin
			b = off[0] ? s[idx][7:0] : s[idx][15:8];
		end
		return b;
	endfunction

endpackage

// ===== rtl/spi_imu_register_slave.sv =====
// SPI IMU register slave: one word per SPI event, one result word per event.
// Path: input register, then result register holding the registered memory read; the
// result word is valid once the word moves from the input to the result register.
// Throughput: one word per cycle while out_stall does not hold the result register.
// Reset: asynchronous arst_n restores the power-on map and sensor samples at once.
`timescale 1ns / 1ps

module spi_imu_register_slave (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [7:0]          rx_byte,
	input  logic [6:0]          host_addr,
	input  logic [7:0]          host_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          tx_byte,
	output logic                soft_reset_done,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic signed [15:0]  cfg_data
);
	import spiimu_pkg::*;

	logic       v_s1;
	logic [1:0] action_s1;
	logic [7:0] rx_s1;
	logic [6:0] haddr_s1;
	logic [7:0] hdata_s1;
	logic       v_s2;
	logic       soft_s2;

	logic         adv;
	logic         s2_free;
	logic         in_take;
	logic         cfg_we;
	reg_op_t      op;
	sensor_bank_t sensor_q;

	assign s2_free   = !v_s2 || !out_stall;
	assign adv       = v_s1 && s2_free;
	assign in_stall  = v_s1 && !s2_free;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = v_s2;
	assign soft_reset_done = soft_s2;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready && cfg_index != 3'd7;

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			rx_s1     <= rx_byte;
			haddr_s1  <= host_addr;
			hdata_s1  <= host_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			soft_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2    <= 1'b1;
				soft_s2 <= op.soft_reset;
			end else if (!out_stall) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_q <= SENSOR_RESET;
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					sensor_q[i] <= cfg_data;
				end
			end
		end
	end

	spiimu_txn u_txn (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.action    (action_s1),
		.rx_byte   (rx_s1),
		.host_addr (haddr_s1),
		.host_data (hdata_s1),
		.op        (op)
	);

	spiimu_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.op      (op),
		.cfg_we  (cfg_we),
		.sensors (sensor_q),
		.tx_byte (tx_byte)
	);

	a_soft_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && soft_reset_done |-> tx_byte == 8'h00)
		else $error("soft reset word carries read data");

	a_adv_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_s2)
		else $error("advanced word lost before result stage");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && out_stall)
		else $error("input stalled while pipeline can move");

	a_op_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> $countones({op.wr_en, op.rd_en, op.soft_reset, op.set_drdy}) <= 1)
		else $error("more than one register operation decoded");

endmodule

// ===== rtl/spiimu_txn.sv =====
// Transaction tracker: address phase, read flag, base address and byte offset.
// Decodes each word into at most one register-file operation. Depends on spiimu_pkg.
`timescale 1ns / 1ps

module spiimu_txn (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [1:0]        action,
	input  logic [7:0]        rx_byte,
	input  logic [6:0]        host_addr,
	input  logic [7:0]        host_data,
	output spiimu_pkg::reg_op_t op
);
	import spiimu_pkg::*;

	logic       addr_seen_q;
	logic       is_read_q;
	logic [6:0] base_q;
	logic [6:0] offset_q;
	logic [6:0] sum;
	logic [6:0] wr_addr;
	action_t    act;

	assign act     = action_t'(action);
	assign sum     = base_q + offset_q;
	assign wr_addr = sum + ADDR_MASK;

	always_comb begin
		op = '0;
		case (act)
			ACT_SEL_RISE: begin
				op.set_drdy = 1'b1;
			end
			ACT_HOST_WR: begin
				op.wr_en   = 1'b1;
				op.wr_addr = host_addr;
				op.wr_data = host_data;
			end
			ACT_SPI_BYTE: begin
				if (!addr_seen_q) begin
					op.rd_en   = rx_byte[READ_FLAG_BIT];
					op.rd_addr = rx_byte[6:0];
				end else if (is_read_q) begin
					op.rd_en   = 1'b1;
					op.rd_addr = sum;
				end else if (wr_addr == PWR_ADDR && rx_byte[PWR_RESET_BIT]) begin
					op.soft_reset = 1'b1;
				end else begin
					op.wr_en   = 1'b1;
					op.wr_addr = wr_addr;
					op.wr_data = rx_byte;
				end
			end
			default: begin
				op = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_seen_q <= 1'b0;
			is_read_q   <= 1'b0;
			base_q      <= '0;
			offset_q    <= '0;
		end else if (adv) begin
			case (act)
				ACT_SEL_FALL, ACT_SEL_RISE: begin
					addr_seen_q <= 1'b0;
					offset_q    <= '0;
				end
				ACT_SPI_BYTE: begin
					if (!addr_seen_q) begin
						is_read_q   <= rx_byte[READ_FLAG_BIT];
						base_q      <= rx_byte[6:0];
						addr_seen_q <= 1'b1;
						offset_q    <= 7'd1;
					end else begin
						offset_q <= offset_q + 7'd1;
					end
				end
				default: begin
					offset_q <= offset_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/spiimu_regfile.sv =====
// Register map: 128-byte memory with per-entry valid bits over the power-on map,
// interrupt-status register and registered read port. Depends on spiimu_pkg.
`timescale 1ns / 1ps

module spiimu_regfile (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  spiimu_pkg::reg_op_t      op,
	input  logic                     cfg_we,
	input  spiimu_pkg::sensor_bank_t sensors,
	output logic [7:0]               tx_byte
);
	import spiimu_pkg::*;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       isr_q;

	logic       rd_en_s2;
	logic       rd_isr_s2;
	logic       rd_valid_s2;
	logic [6:0] rd_addr_s2;
	logic [7:0] rd_data_s2;
	logic [7:0] isr_s2;

	logic mem_we;

	assign mem_we = adv && op.wr_en && op.wr_addr != INT_STATUS_ADDR;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[op.wr_addr] <= op.wr_data;
		end
		if (adv) begin
			rd_data_s2 <= mem[op.rd_addr];
			rd_addr_s2 <= op.rd_addr;
			isr_s2     <= isr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			isr_q       <= DATA_RDY;
			rd_en_s2    <= 1'b0;
			rd_isr_s2   <= 1'b0;
			rd_valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				rd_en_s2    <= op.rd_en;
				rd_isr_s2   <= op.rd_addr == INT_STATUS_ADDR;
				rd_valid_s2 <= valid_q[op.rd_addr];
			end
			if (cfg_we) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (7'(i) >= SENSOR_BASE && 7'(i) <= SENSOR_LAST) begin
						valid_q[i] <= 1'b0;
					end
				end
				isr_q <= isr_q | DATA_RDY;
			end else if (adv && op.soft_reset) begin
				valid_q <= '0;
				isr_q   <= DATA_RDY;
			end else if (adv && op.wr_en) begin
				if (op.wr_addr == INT_STATUS_ADDR) begin
					isr_q <= op.wr_data;
				end else begin
					valid_q[op.wr_addr] <= 1'b1;
				end
			end else if (adv && op.set_drdy) begin
				isr_q <= isr_q | DATA_RDY;
			end
		end
	end

	always_comb begin
		if (!rd_en_s2) begin
			tx_byte = 8'h00;
		end else if (rd_isr_s2) begin
			tx_byte = isr_s2;
		end else if (rd_valid_s2) begin
			tx_byte = rd_data_s2;
		end else begin
			tx_byte = default_byte(rd_addr_s2, sensors);
		end
	end

endmodule
